@@ hdl/kwc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyword counter package
// Request codes, reply kinds, the sorted keyword table and the types shared
// between the word tracker, the count bank and the top level.
// ----------------------------------------------------------------------------
package kwc_pkg;

    localparam int NUM_KEYWORDS = 11;
    localparam int KW_CHARS     = 8;
    localparam int KW_CHAR_AW   = $clog2(KW_CHARS);
    localparam int KW_IDX_W     = 4;

    typedef enum logic [1:0] {
        REQ_TEXT = 2'd0,
        REQ_EOI  = 2'd1,
        REQ_READ = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    localparam logic KIND_HIT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Sorted keyword table, unused character slots are zero.
    localparam logic [7:0] KW_TEXT [NUM_KEYWORDS][KW_CHARS] = '{
        '{"a", "u", "t", "o", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"b", "r", "e", "a", "k", 8'd0, 8'd0, 8'd0},
        '{"c", "a", "s", "e", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"c", "h", "a", "r", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"c", "o", "n", "s", "t", 8'd0, 8'd0, 8'd0},
        '{"c", "o", "n", "t", "i", "n", "u", "e"},
        '{"d", "e", "f", "a", "u", "l", "t", 8'd0},
        '{"u", "n", "s", "i", "g", "n", "e", "d"},
        '{"v", "o", "i", "d", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"v", "o", "l", "a", "t", "i", "l", "e"},
        '{"w", "h", "i", "l", "e", 8'd0, 8'd0, 8'd0}
    };

    localparam int KW_LEN [NUM_KEYWORDS] = '{4, 5, 4, 4, 5, 8, 7, 8, 4, 8, 5};

    // Result of one step of the word tracker.
    typedef struct packed {
        logic                hit;
        logic [KW_IDX_W-1:0] idx;
    } t_word_evt;

endpackage

`default_nettype wire

@@ hdl/kwc_word_tracker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyword counter word tracker
// Follows word boundaries in the byte stream, keeps the first characters of
// the open word and matches a finished word against the keyword table.
// ----------------------------------------------------------------------------
module kwc_word_tracker
    import kwc_pkg::*;
#(
    parameter int MAX_WORD = 100
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire t_req      i_req,
    input  wire logic [7:0] i_char,
    output t_word_evt      o_evt
);

    localparam int LEN_W = $clog2(MAX_WORD);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_WORD - 1);

    logic                  r_in_word;
    logic                  n_in_word;
    logic [LEN_W-1:0]      r_len;
    logic [LEN_W-1:0]      n_len;
    logic [7:0]            r_chars [KW_CHARS];
    logic                  chr_wr;
    logic [KW_CHAR_AW-1:0] chr_addr;
    logic                  finish;
    logic                  is_letter;
    logic                  is_digit;
    logic [NUM_KEYWORDS-1:0] kw_match;
    logic [KW_IDX_W-1:0]   match_idx;
    logic                  chars_eq;

    assign is_letter = ((i_char >= "a") && (i_char <= "z")) ||
                       ((i_char >= "A") && (i_char <= "Z"));
    assign is_digit  = (i_char >= "0") && (i_char <= "9");

    // Characters past a keyword's length are masked, so unwritten slots never count.
    always_comb begin
        chars_eq = 1'b1;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            chars_eq = 1'b1;
            for (int i = 0; i < KW_CHARS; i++) begin
                if (i < KW_LEN[k]) begin
                    chars_eq = chars_eq && (r_chars[i] == KW_TEXT[k][i]);
                end
            end
            kw_match[k] = (r_len == LEN_W'(KW_LEN[k])) && chars_eq;
        end
    end

    always_comb begin
        match_idx = '0;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            if (kw_match[k]) begin
                match_idx = KW_IDX_W'(k);
            end
        end
    end

    always_comb begin
        n_in_word = r_in_word;
        n_len     = r_len;
        finish    = 1'b0;
        chr_wr    = 1'b0;
        chr_addr  = '0;
        if (i_en) begin
            unique case (i_req)
                REQ_TEXT: begin
                    if (r_in_word) begin
                        if (is_letter || is_digit) begin
                            if (r_len < LEN_W'(KW_CHARS)) begin
                                chr_wr   = 1'b1;
                                chr_addr = r_len[KW_CHAR_AW-1:0];
                            end
                            // A word cut at the length limit is longer than any
                            // keyword, so it closes without a match.
                            if (LEN_W'(r_len + 1'b1) == LEN_LIMIT) begin
                                n_in_word = 1'b0;
                                n_len     = '0;
                            end else begin
                                n_len = LEN_W'(r_len + 1'b1);
                            end
                        end else begin
                            finish = 1'b1;
                        end
                    end else if (is_letter) begin
                        n_in_word = 1'b1;
                        n_len     = LEN_W'(1);
                        chr_wr    = 1'b1;
                        chr_addr  = '0;
                    end
                end
                REQ_EOI: begin
                    finish = r_in_word;
                end
                REQ_READ, REQ_NONE: begin
                end
            endcase
            if (finish) begin
                n_in_word = 1'b0;
                n_len     = '0;
            end
        end
    end

    assign o_evt.hit = finish && (|kw_match);
    assign o_evt.idx = match_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word <= 1'b0;
            r_len     <= '0;
        end else begin
            r_in_word <= n_in_word;
            r_len     <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (chr_wr) begin
            r_chars[chr_addr] <= i_char;
        end
    end

    a_len_tracks_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_word == (r_len != '0))
        else $error("word length and in-word flag disagree");

endmodule

`default_nettype wire

@@ hdl/kwc_count_bank.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyword counter count bank
// One saturating counter per keyword with a single shared read and update
// port. Reads of indexes beyond the table return zero.
// ----------------------------------------------------------------------------
module kwc_count_bank
    import kwc_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_inc,
    input  wire logic [KW_IDX_W-1:0]   i_sel,
    output logic      [COUNT_BITS-1:0] o_value
);

    logic [COUNT_BITS-1:0] r_count [NUM_KEYWORDS];
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] n_count;

    assign cur     = (i_sel < KW_IDX_W'(NUM_KEYWORDS)) ? r_count[i_sel] : '0;
    assign n_count = (&cur) ? cur : COUNT_BITS'(cur + 1'b1);
    assign o_value = i_inc ? n_count : cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYWORDS; k++) begin
                r_count[k] <= '0;
            end
        end else if (i_inc) begin
            r_count[i_sel] <= n_count;
        end
    end

endmodule

`default_nettype wire

@@ hdl/keyword_token_counter_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyword token counter
// Counts C keyword occurrences in a byte stream and answers count reads.
// ----------------------------------------------------------------------------
// Input channel s_axis: tuser carries the request (text byte, end of input,
// count read, or an ignored code), tdata the text byte and the key index.
// Output channel m_axis: tuser says whether the reply is a keyword hit from
// the stream or the answer to a read, tdata holds the keyword index and its
// count (after the update for a hit).
// An accepted transfer is held in an input register; once the output register
// can advance, the word tracker and the count bank handle it and the reply
// lands in the output register.
// One request is taken every cycle while the output side keeps up, since each
// request is finished in a single pass with at most one counter update.
// Requests that produce no reply (most text bytes) leave the output alone.
// When the receiver stalls with a reply pending, processing stops and the
// input register fills, then s_axis_tready drops until the reply is taken.
// Reset clears the word state and all counters.
// ----------------------------------------------------------------------------
module keyword_token_counter_top
    import kwc_pkg::*;
#(
    parameter int MAX_WORD   = 100,
    parameter int COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // char_byte[7:0], key_index[11:8]
    input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // hit_index[3:0], hit_count[19:4]
    output logic [0:0]       m_axis_tuser   // reply_kind[0]
);

    localparam int WIDE_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic                  r_in_valid;
    t_req                  r_req;
    logic [7:0]            r_char;
    logic [KW_IDX_W-1:0]   r_idx;

    logic                  r_out_valid;
    logic                  r_kind;
    logic [KW_IDX_W-1:0]   r_hit_idx;
    logic [15:0]           r_hit_cnt;

    logic                  advance;
    logic                  proc;
    logic                  is_read;
    logic                  has_result;
    t_word_evt             evt;
    logic [KW_IDX_W-1:0]   bank_sel;
    logic [COUNT_BITS-1:0] bank_value;
    logic [WIDE_BITS-1:0]  wide_value;

    assign advance       = !r_out_valid || m_axis_tready;
    assign proc          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign is_read       = (r_req == REQ_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_req  <= t_req'(s_axis_tuser);
            r_char <= s_axis_tdata[7:0];
            r_idx  <= s_axis_tdata[11:8];
        end
    end

    kwc_word_tracker #(
        .MAX_WORD (MAX_WORD)
    ) u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (proc),
        .i_req   (r_req),
        .i_char  (r_char),
        .o_evt   (evt)
    );

    assign bank_sel = is_read ? r_idx : evt.idx;

    kwc_count_bank #(
        .COUNT_BITS (COUNT_BITS)
    ) u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_inc   (evt.hit),
        .i_sel   (bank_sel),
        .o_value (bank_value)
    );

    assign wide_value = WIDE_BITS'(bank_value);
    assign has_result = proc && (is_read || evt.hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (has_result) begin
            r_kind    <= is_read ? KIND_READ : KIND_HIT;
            r_hit_idx <= bank_sel;
            r_hit_cnt <= wide_value[15:0];
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {4'd0, r_hit_cnt, r_hit_idx};
    assign m_axis_tuser[0] = r_kind;

    a_read_replies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && (r_req == REQ_READ) |=> m_axis_tvalid && (m_axis_tuser[0] == KIND_READ))
        else $error("count read produced no read reply");

    a_ignored_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && (r_req == REQ_NONE) |=> !m_axis_tvalid)
        else $error("ignored request produced a reply");

    a_hit_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == KIND_HIT) |->
            (m_axis_tdata[3:0] < KW_IDX_W'(NUM_KEYWORDS)))
        else $error("keyword hit index beyond table");

    // With counters wider than the count field, the low bits wrap to zero.
    a_hit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == KIND_HIT) |->
            ((COUNT_BITS > 16) || (m_axis_tdata[19:4] != 16'd0)))
        else $error("keyword hit reported a zero count");

endmodule

`default_nettype wire

@@ sim/kwc_reply_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword counter reply checker
// Watches both stream channels of the keyword token counter. Every accepted
// request is run through a local model of the word scanner and the keyword
// counters. The replies it predicts are queued and compared, field by field,
// with the replies the block delivers.
// ----------------------------------------------------------------------------
module kwc_reply_checker
    import kwc_pkg::*;
#(
    parameter int MAX_WORD   = 100,
    parameter int COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [15:0] i_s_tdata,   // char_byte[7:0], key_index[11:8]
    input  wire logic [1:0]  i_s_tuser,   // req_type[1:0]
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [23:0] i_m_tdata,   // hit_index[3:0], hit_count[19:4]
    input  wire logic [0:0]  i_m_tuser,   // reply_kind[0]
    output int               o_fail_count,
    output int               o_pending
);

    localparam int KW_TOTAL = 11;

    // Keyword spellings, right-aligned in 64 bits, in table order.
    localparam logic [63:0] KW_SPELLING [KW_TOTAL] = '{
        "auto", "break", "case", "char", "const", "continue", "default",
        "unsigned", "void", "volatile", "while"
    };
    localparam int KW_LENGTH [KW_TOTAL] = '{4, 5, 4, 4, 5, 8, 7, 8, 4, 8, 5};

    typedef struct packed {
        logic        kind;
        logic [3:0]  index;
        logic [15:0] count;
    } kwc_reply;

    logic                  in_word;
    logic [6:0]            word_len;
    logic [63:0]           word_bits;    // first eight characters, oldest on top
    logic [COUNT_BITS-1:0] kw_count [KW_TOTAL];
    kwc_reply              pending_replies [$];
    int                    fail_count;

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Closes the open word and bumps the matching counter, if any.
    task automatic close_word(output bit fired, output kwc_reply r);
        fired = 1'b0;
        r     = '0;
        for (int k = 0; k < KW_TOTAL; k++) begin
            if (!fired && word_len == 7'(KW_LENGTH[k]) && word_bits == KW_SPELLING[k]) begin
                if (kw_count[k] != '1)
                    kw_count[k] = kw_count[k] + 1'b1;
                r     = '{kind: KIND_HIT, index: 4'(k), count: 16'(kw_count[k])};
                fired = 1'b1;
            end
        end
        in_word  = 1'b0;
        word_len = '0;
    endtask

    task automatic scan_request(input logic [1:0] req, input logic [7:0] c,
                                input logic [3:0] idx);
        kwc_reply r;
        bit       fired;
        fired = 1'b0;
        r     = '0;
        case (req)
            REQ_READ: begin
                r.kind  = KIND_READ;
                r.index = idx;
                r.count = (idx < KW_TOTAL) ? 16'(kw_count[idx]) : 16'd0;
                fired   = 1'b1;
            end
            REQ_EOI: begin
                if (in_word)
                    close_word(fired, r);
            end
            REQ_TEXT: begin
                if (in_word) begin
                    if (is_letter(c) || is_digit(c)) begin
                        if (word_len < 7'd8)
                            word_bits = {word_bits[55:0], c};
                        word_len = word_len + 1'b1;
                        // A word that reaches the length limit ends right away.
                        if (word_len >= 7'(MAX_WORD - 1))
                            close_word(fired, r);
                    end else begin
                        close_word(fired, r);
                    end
                end else if (is_letter(c)) begin
                    in_word   = 1'b1;
                    word_bits = 64'(c);
                    word_len  = 7'd1;
                end
            end
            default: ;
        endcase
        if (fired)
            pending_replies.push_back(r);
    endtask

    always @(posedge i_clk) begin
        kwc_reply got;
        kwc_reply want;
        if (!i_rst_n) begin
            in_word   = 1'b0;
            word_len  = '0;
            word_bits = '0;
            for (int k = 0; k < KW_TOTAL; k++)
                kw_count[k] = '0;
            pending_replies.delete();
            fail_count = 0;
        end else begin
            // The output side is handled first: a reply can never belong to a
            // request taken at the same edge.
            if (i_m_tvalid && i_m_tready) begin
                got = '{kind: i_m_tuser[0], index: i_m_tdata[3:0], count: i_m_tdata[19:4]};
                if (pending_replies.size() == 0) begin
                    $error("unexpected reply: kind %0d index %0d count %0d",
                           got.kind, got.index, got.count);
                    fail_count++;
                end else begin
                    want = pending_replies.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("reply_kind mismatch: expected %0d, actual %0d",
                               want.kind, got.kind);
                        fail_count++;
                    end
                    if (got.index !== want.index) begin
                        $error("hit_index mismatch: expected %0d, actual %0d",
                               want.index, got.index);
                        fail_count++;
                    end
                    if (got.count !== want.count) begin
                        $error("hit_count mismatch: expected %0d, actual %0d",
                               want.count, got.count);
                        fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                scan_request(i_s_tuser, i_s_tdata[7:0], i_s_tdata[11:8]);
        end
        o_fail_count = fail_count;
        o_pending    = pending_replies.size();
    end

endmodule

@@ sim/tb_keyword_token_counter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword token counter testbench
// Feeds text, end-of-input and count-read requests into the block with random
// gaps on the input and random stalls on the output. Replies are checked by
// the reply checker. A narrow counter width exercises the zero padding of the
// count field.
// ----------------------------------------------------------------------------
module tb_keyword_token_counter_top;
    import kwc_pkg::*;

    localparam int MAX_WORD     = 100;
    localparam int COUNT_BITS   = 8;
    localparam int RANDOM_ITEMS = 1400;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata   = '0;    // char_byte[7:0], key_index[11:8]
    logic [1:0]  s_axis_tuser   = REQ_NONE; // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [23:0] m_axis_tdata;           // hit_index[3:0], hit_count[19:4]
    logic [0:0]  m_axis_tuser;           // reply_kind[0]

    int fail_count;
    int pending;
    int sent_items;
    bit no_gaps;

    string keyword_spellings [11] = '{
        "auto", "break", "case", "char", "const", "continue", "default",
        "unsigned", "void", "volatile", "while"
    };

    keyword_token_counter_top #(
        .MAX_WORD   (MAX_WORD),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    kwc_reply_checker #(
        .MAX_WORD   (MAX_WORD),
        .COUNT_BITS (COUNT_BITS)
    ) reply_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("FAIL keyword_token_counter_top");
        $finish;
    end

    always @(negedge i_clk)
        m_axis_tready <= no_gaps || ($urandom_range(99) >= 9);

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(input logic [1:0] req, input logic [7:0] c,
                                input logic [3:0] idx);
        while (!no_gaps && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, idx, c};
        s_axis_tuser  <= req;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        @(negedge i_clk);
        if (req != REQ_NONE)
            sent_items++;
    endtask

    task automatic send_text(input logic [7:0] c);
        send_request(REQ_TEXT, c, 4'($urandom));
    endtask

    task automatic send_read(input logic [3:0] idx);
        send_request(REQ_READ, 8'($urandom), idx);
    endtask

    task automatic send_eoi();
        send_request(REQ_EOI, 8'($urandom), 4'($urandom));
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_text(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        int v;
        v = $urandom_range(51);
        return (v < 26) ? 8'("a" + v) : 8'("A" + v - 26);
    endfunction

    function automatic logic [7:0] rand_alnum();
        int v;
        v = $urandom_range(61);
        if (v < 52)
            return rand_letter();
        return 8'("0" + v - 52);
    endfunction

    // Something that ends a word: whitespace, punctuation, a high byte or EOI.
    task automatic send_word_end();
        int r;
        r = $urandom_range(9);
        case (r)
            0, 1, 2, 3: send_text(8'h20);
            4, 5:       send_text(8'($urandom_range(9, 13)));
            6:          send_eoi();
            7:          send_text(8'($urandom_range(33, 47)));
            8:          send_text(8'($urandom_range(128, 255)));
            default:    send_text(8'($urandom_range(58, 64)));
        endcase
    endtask

    task automatic send_keyword(input int k);
        string s;
        int    pos;
        s = keyword_spellings[k];
        // Now and then one letter goes upper case, which must not match.
        if ($urandom_range(19) == 0) begin
            pos    = $urandom_range(s.len() - 1);
            s[pos] = s[pos] - 8'd32;
        end
        send_string(s);
    endtask

    initial begin
        int r;
        int len;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening.
        send_read(4'd0);
        send_read(4'd15);
        send_string("auto ");
        send_string("while(");
        send_text(8'hFF);
        send_text("7");
        send_string("char");
        send_eoi();
        send_string("ca");
        send_read(4'd2);
        send_string("se");
        send_text(8'h09);
        send_request(REQ_NONE, 8'($urandom), 4'($urandom));
        send_read(4'd2);

        // Random text, mostly well-formed words with noise in between.
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS) begin
            no_gaps = (sent_items >= 500 && sent_items < 800);
            r = $urandom_range(99);
            if (r < 45) begin
                send_keyword($urandom_range(10));
                send_word_end();
            end else if (r < 60) begin
                len = $urandom_range(1, 12);
                send_text(rand_letter());
                for (int i = 1; i < len; i++)
                    send_text(rand_alnum());
                send_word_end();
            end else if (r < 62) begin
                // Long word around the length limit, then a keyword.
                len = $urandom_range(MAX_WORD - 4, MAX_WORD + 2);
                send_text(rand_letter());
                for (int i = 1; i < len; i++)
                    send_text(rand_alnum());
                send_keyword($urandom_range(10));
                send_word_end();
            end else if (r < 72) begin
                send_read(4'($urandom_range(15)));
            end else if (r < 76) begin
                send_eoi();
            end else if (r < 80) begin
                send_request(REQ_NONE, 8'($urandom), 4'($urandom));
            end else begin
                send_text(8'($urandom_range(255)));
            end
        end
        no_gaps = 1'b0;

        for (int i = 0; i < 16; i++)
            send_read(4'(i));

        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0)
            $display("PASS keyword_token_counter_top");
        else
            $display("FAIL keyword_token_counter_top");
        $finish;
    end

endmodule
